/* rtl/core/pccm_pkg.sv */
// ----------------------------------------------------------------------------
// pccm_pkg
// Shared widths, defaults and status types for the pair-counting
// confusion matrix block.
// ----------------------------------------------------------------------------
package pccm_pkg;

	// field widths at the ports
	localparam int LABEL_W   = 16;
	localparam int PAIR_W    = 19;
	localparam int COUNT_W   = 11;

	// parameter defaults
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int LABEL_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF  = 2;

	// status of the back end, seen by the top level
	typedef struct packed {
		logic counting;   // pair loop running
		logic finishing;  // counts final, waiting for the output register
		logic pop;        // a queued word is taken this cycle
	} pccm_stat_t;

endpackage

/* rtl/core/pccm_front.sv */
// ----------------------------------------------------------------------------
// pccm_front
// Accepts input words, decides store or drop against capacity, tracks the
// element count and the drop flag of the current set, and pushes one
// classified word into the queue per accepted input.
// ----------------------------------------------------------------------------
module pccm_front
	import pccm_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LABEL_BITS   = LABEL_BITS_DEF,
	localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LABEL_W-1:0]    label_first,
	input  logic [LABEL_W-1:0]    label_second,
	input  logic                  last,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [LABEL_BITS-1:0] p_label_first,
	output logic [LABEL_BITS-1:0] p_label_second,
	output logic [CW-1:0]         p_cnt,
	output logic                  p_store,
	output logic                  p_last,
	output logic                  p_ovf
);

	logic [CW-1:0] cnt_q;
	logic          drop_q;

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// classify the word
	assign p_store        = cnt_q < CW'(MAX_ELEMENTS);
	assign p_label_first  = LABEL_BITS'(label_first);
	assign p_label_second = LABEL_BITS'(label_second);
	assign p_cnt          = cnt_q;
	assign p_last         = last;
	assign p_ovf          = drop_q || !p_store;

	// advance count and drop flag, clear both at the end of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (q_push) begin
			if (last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_q + CW'(p_store);
				drop_q <= p_ovf;
			end
		end
	end

endmodule

/* rtl/core/pccm_queue.sv */
// ----------------------------------------------------------------------------
// pccm_queue
// Small first-in first-out buffer between the front and the back end.
// ----------------------------------------------------------------------------
module pccm_queue
	import pccm_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] pop_data
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	assign full     = fill_q == NW'(DEPTH);
	assign valid    = fill_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	// hold pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			fill_q <= fill_q + NW'(push) - NW'(pop);
		end
	end

endmodule

/* rtl/core/pccm_back.sv */
// ----------------------------------------------------------------------------
// pccm_back
// Stores labels of queued words, and on the final word of a set walks all
// unordered pairs one per cycle through a two-read label memory, counting
// the four pair classes. Holds the result in an output register.
// ----------------------------------------------------------------------------
module pccm_back
	import pccm_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LABEL_BITS   = LABEL_BITS_DEF,
	localparam int CW = $clog2(MAX_ELEMENTS + 1),
	localparam int AW = $clog2(MAX_ELEMENTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [LABEL_BITS-1:0] q_label_first,
	input  logic [LABEL_BITS-1:0] q_label_second,
	input  logic [CW-1:0]         q_cnt,
	input  logic                  q_store,
	input  logic                  q_last,
	input  logic                  q_ovf,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PAIR_W-1:0]     together_both,
	output logic [PAIR_W-1:0]     apart_both,
	output logic [PAIR_W-1:0]     apart_first_only,
	output logic [PAIR_W-1:0]     apart_second_only,
	output logic [COUNT_W-1:0]    element_count,
	output logic                  overflow,
	output pccm_stat_t            stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [LABEL_BITS-1:0] first_mem  [MAX_ELEMENTS];
	logic [LABEL_BITS-1:0] second_mem [MAX_ELEMENTS];

	logic [LABEL_BITS-1:0] fa_s1, fb_s1, sa_s1, sb_s1;
	logic                  rd_v_s1;

	logic [CW-1:0]     n_q, i_q, j_q;
	logic              ovf_q;
	logic [PAIR_W-1:0] both_q, neither_q, same2_only_q, same1_only_q;
	logic              out_valid_q;

	logic issue, same1, same2, fin_go, wr_en;

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign wr_en  = q_pop && q_store;
	assign issue  = (state_q == ST_COUNT) && (j_q < n_q);
	assign same1  = fa_s1 == fb_s1;
	assign same2  = sa_s1 == sb_s1;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign out_valid      = out_valid_q;
	assign stat.counting  = state_q == ST_COUNT;
	assign stat.finishing = state_q == ST_FIN;
	assign stat.pop       = q_pop;

	// label memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			first_mem[q_cnt[AW-1:0]]  <= q_label_first;
			second_mem[q_cnt[AW-1:0]] <= q_label_second;
		end
		if (issue) begin
			fa_s1 <= first_mem[i_q[AW-1:0]];
			fb_s1 <= first_mem[j_q[AW-1:0]];
			sa_s1 <= second_mem[i_q[AW-1:0]];
			sb_s1 <= second_mem[j_q[AW-1:0]];
		end
	end

	// sequence the pair walk, accumulate, and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			rd_v_s1           <= 1'b0;
			out_valid_q       <= 1'b0;
			n_q               <= '0;
			i_q               <= '0;
			j_q               <= '0;
			ovf_q             <= 1'b0;
			both_q            <= '0;
			neither_q         <= '0;
			same2_only_q      <= '0;
			same1_only_q      <= '0;
			together_both     <= '0;
			apart_both        <= '0;
			apart_first_only  <= '0;
			apart_second_only <= '0;
			element_count     <= '0;
			overflow          <= 1'b0;
		end else begin
			rd_v_s1 <= issue;

			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end

			// classify the pair read last cycle
			if (rd_v_s1) begin
				priority if (same1 && same2) begin
					both_q <= both_q + PAIR_W'(1);
				end else if (!same1 && !same2) begin
					neither_q <= neither_q + PAIR_W'(1);
				end else if (same2) begin
					same2_only_q <= same2_only_q + PAIR_W'(1);
				end else begin
					same1_only_q <= same1_only_q + PAIR_W'(1);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_last) begin
						n_q          <= q_cnt + CW'(q_store);
						ovf_q        <= q_ovf;
						i_q          <= '0;
						j_q          <= CW'(1);
						both_q       <= '0;
						neither_q    <= '0;
						same2_only_q <= '0;
						same1_only_q <= '0;
						state_q      <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (issue) begin
						if (j_q + CW'(1) < n_q) begin
							j_q <= j_q + CW'(1);
						end else begin
							i_q <= i_q + CW'(1);
							j_q <= i_q + CW'(2);
						end
					end else if (!rd_v_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						together_both     <= both_q;
						apart_both        <= neither_q;
						apart_first_only  <= same2_only_q;
						apart_second_only <= same1_only_q;
						element_count     <= COUNT_W'(n_q);
						overflow          <= ovf_q;
						out_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/pair_counting_confusion_matrix.sv */
// ----------------------------------------------------------------------------
// pair_counting_confusion_matrix
// Pair-counting confusion matrix of two clusterings over one data set.
//
//   channel | signals                                   | dir | word
//   --------+-------------------------------------------+-----+------------------
//   in      | in_valid, in_ready                        | in  | label_first,
//           |                                           |     | label_second, last
//   out     | out_valid, out_ready                      | out | together_both,
//           |                                           |     | apart_both,
//           |                                           |     | apart_first_only,
//           |                                           |     | apart_second_only,
//           |                                           |     | element_count,
//           |                                           |     | overflow
//
// The back end takes a word that is not last from its idle state. A last
// word starts the pair walk over the N(N-1)/2 unordered pairs of the N
// stored elements, one pair a cycle through the two read ports of the label
// memory, before the result is registered. The input queue keeps taking
// words while the back end stores or counts, until it is full. Reset clears
// control, counters and outputs but not the label memory, which needs no
// clearing since only entries of the current set are read. A result stalled
// at the output holds the back end in its final state.
// ----------------------------------------------------------------------------
module pair_counting_confusion_matrix
	import pccm_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LABEL_BITS   = LABEL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [LABEL_W-1:0] label_first,
	input  logic [LABEL_W-1:0] label_second,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PAIR_W-1:0]  together_both,
	output logic [PAIR_W-1:0]  apart_both,
	output logic [PAIR_W-1:0]  apart_first_only,
	output logic [PAIR_W-1:0]  apart_second_only,
	output logic [COUNT_W-1:0] element_count,
	output logic               overflow
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int QW = 2 * LABEL_BITS + CW + 3;

	logic                  q_push, q_full, q_valid, q_pop;
	logic [QW-1:0]         push_word, pop_word;
	logic [LABEL_BITS-1:0] p_label_first, p_label_second;
	logic [CW-1:0]         p_cnt;
	logic                  p_store, p_last, p_ovf;
	logic [LABEL_BITS-1:0] b_label_first, b_label_second;
	logic [CW-1:0]         b_cnt;
	logic                  b_store, b_last, b_ovf;
	pccm_stat_t            stat;

	// classify incoming words
	pccm_front #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.LABEL_BITS   (LABEL_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.label_first    (label_first),
		.label_second   (label_second),
		.last           (last),
		.q_full         (q_full),
		.q_push         (q_push),
		.p_label_first  (p_label_first),
		.p_label_second (p_label_second),
		.p_cnt          (p_cnt),
		.p_store        (p_store),
		.p_last         (p_last),
		.p_ovf          (p_ovf)
	);

	assign push_word = {p_label_first, p_label_second, p_cnt, p_store, p_last, p_ovf};
	assign {b_label_first, b_label_second, b_cnt, b_store, b_last, b_ovf} = pop_word;

	// decouple front and back
	pccm_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_word)
	);

	// store labels and count pairs
	pccm_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.LABEL_BITS   (LABEL_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_label_first     (b_label_first),
		.q_label_second    (b_label_second),
		.q_cnt             (b_cnt),
		.q_store           (b_store),
		.q_last            (b_last),
		.q_ovf             (b_ovf),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.together_both     (together_both),
		.apart_both        (apart_both),
		.apart_first_only  (apart_first_only),
		.apart_second_only (apart_second_only),
		.element_count     (element_count),
		.overflow          (overflow),
		.stat              (stat)
	);

	// the back end takes a word only when one is queued
	a_pop_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> q_valid)
		else $error("back end popped an empty queue");

	// no word is taken while the pair walk runs or a result waits
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.counting || stat.finishing) |-> !stat.pop)
		else $error("back end popped while busy");

	// a new result appears only out of the final state
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.finishing))
		else $error("result raised outside the final state");

	// the walk never runs without a prior set end
	a_count_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.counting) |-> $past(stat.pop && b_last))
		else $error("pair walk started without a last word");

endmodule
